/* src/pdct_pkg.sv */
// ----------------------------------------------------------------------------
// pdct_pkg
// Shared types and constants for the prescaled down-counting timer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdct_pkg;

    // request kind
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    // bus register word index
    typedef enum logic [2:0] {
        REG_CFG0    = 3'd0,
        REG_CFG1    = 3'd1,
        REG_CONTROL = 3'd2,
        REG_BUFFER  = 3'd3,
        REG_COMPARE = 3'd4,
        REG_COUNT   = 3'd5,
        REG_STATUS  = 3'd6
    } reg_idx_t;

    // configuration port index
    typedef enum logic [0:0] {
        CFG_PRESCALE = 1'b0,
        CFG_DIVIDER  = 1'b1
    } cfg_idx_t;

    // control word, bit 3 down to bit 0
    typedef struct packed {
        logic auto_reload;
        logic inverter;
        logic update;
        logic run;
    } ctrl_t;

    typedef struct packed {
        logic flag;
        logic enable;
    } stat_t;

    localparam int STAT_EN_BIT   = 0;
    localparam int STAT_FLAG_BIT = 5;
    localparam logic [2:0] DIV_SEL_MAX = 3'd4;

    // terminal count of the power-of-two divider; selects above 4 act as 4
    function automatic logic [3:0] div_limit(input logic [2:0] sel);
        logic [2:0] s;
        s = (sel > DIV_SEL_MAX) ? DIV_SEL_MAX : sel;
        return 4'((5'd1 << s) - 5'd1);
    endfunction

endpackage

`default_nettype wire

/* src/prescaled_down_counting_timer.sv */
// ----------------------------------------------------------------------------
// prescaled_down_counting_timer
// One-channel prescaled auto-reload down-counting timer behind a stream.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel: s_tuser carries the request kind
//   (tick, register read, register write) and the register index, s_tdata
//   the write value. Every request gives exactly one result on the m_
//   channel: read data, the interrupt line after the request, and a flag
//   that the tick found the counter at zero.
//   The result is valid in the cycle after request accept. Throughput is
//   one request per cycle while results are taken, set by the single-pass
//   state update between the timer state registers and the result register.
//   When the receiver stalls, the result register holds its value and
//   s_tready stays high only in a cycle where the held result is taken.
//   The cfg_ port writes the prescale and divider settings directly (index
//   0 prescale minus one, 1 divider select); bus writes reach them too.
//   Reset clears all counters, buffers, control and status: the timer is
//   stopped and no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module prescaled_down_counting_timer #(
    parameter int COUNT_WIDTH    = 32,
    parameter int PRESCALE_WIDTH = 8,
    localparam int CfgWidth      = (PRESCALE_WIDTH > 3) ? PRESCALE_WIDTH : 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request channel
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [31:0]         s_tdata,   // [31:0] write_data
    input  wire logic [4:0]          s_tuser,   // [1:0] opcode, [4:2] reg_index
    // result channel
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata,   // [31:0] read_data, [32] irq_line,
                                                // [33] expired, [39:34] zero
    // configuration write port
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [CfgWidth-1:0] cfg_data
);
    import pdct_pkg::*;

    // timer state
    logic [PRESCALE_WIDTH-1:0] psc_limit_reg, psc_limit_next;
    logic [2:0]                div_sel_reg, div_sel_next;
    logic [PRESCALE_WIDTH-1:0] psc_cnt_reg, psc_cnt_next;
    logic [3:0]                div_cnt_reg, div_cnt_next;
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [COUNT_WIDTH-1:0]    reload_reg, reload_next;
    logic [COUNT_WIDTH-1:0]    compare_reg, compare_next;
    ctrl_t                     ctrl_reg, ctrl_next;
    stat_t                     stat_reg, stat_next;

    // core outputs before commit
    logic [PRESCALE_WIDTH-1:0] core_psc_limit;
    logic [2:0]                core_div_sel;
    logic [PRESCALE_WIDTH-1:0] core_psc_cnt;
    logic [3:0]                core_div_cnt;
    logic [COUNT_WIDTH-1:0]    core_count;
    logic [COUNT_WIDTH-1:0]    core_reload;
    logic [COUNT_WIDTH-1:0]    core_compare;
    ctrl_t                     core_ctrl;
    stat_t                     core_stat;
    logic [31:0]               core_rdata;
    logic                      core_irq;
    logic                      core_expired;

    // result register
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [39:0]               m_tdata_reg;

    logic                      accept;

    // take a request whenever the result slot is free or drains this cycle
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    pdct_core #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .PRESCALE_WIDTH (PRESCALE_WIDTH)
    ) u_core (
        .op             (op_t'(s_tuser[1:0])),
        .reg_index      (reg_idx_t'(s_tuser[4:2])),
        .write_data     (s_tdata),
        .psc_limit      (psc_limit_reg),
        .div_sel        (div_sel_reg),
        .psc_cnt        (psc_cnt_reg),
        .div_cnt        (div_cnt_reg),
        .count          (count_reg),
        .reload         (reload_reg),
        .compare        (compare_reg),
        .ctrl           (ctrl_reg),
        .stat           (stat_reg),
        .psc_limit_next (core_psc_limit),
        .div_sel_next   (core_div_sel),
        .psc_cnt_next   (core_psc_cnt),
        .div_cnt_next   (core_div_cnt),
        .count_next     (core_count),
        .reload_next    (core_reload),
        .compare_next   (core_compare),
        .ctrl_next      (core_ctrl),
        .stat_next      (core_stat),
        .read_data      (core_rdata),
        .irq_line       (core_irq),
        .expired        (core_expired)
    );

    // commit core results on accept; config port writes land when idle
    always_comb
    begin
        psc_limit_next = psc_limit_reg;
        div_sel_next   = div_sel_reg;
        psc_cnt_next   = psc_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        count_next     = count_reg;
        reload_next    = reload_reg;
        compare_next   = compare_reg;
        ctrl_next      = ctrl_reg;
        stat_next      = stat_reg;
        if (accept)
        begin
            psc_limit_next = core_psc_limit;
            div_sel_next   = core_div_sel;
            psc_cnt_next   = core_psc_cnt;
            div_cnt_next   = core_div_cnt;
            count_next     = core_count;
            reload_next    = core_reload;
            compare_next   = core_compare;
            ctrl_next      = core_ctrl;
            stat_next      = core_stat;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PRESCALE: psc_limit_next = cfg_data[PRESCALE_WIDTH-1:0];
                CFG_DIVIDER:  div_sel_next   = cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (accept)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psc_limit_reg <= '0;
            div_sel_reg   <= '0;
            psc_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            count_reg     <= '0;
            reload_reg    <= '0;
            compare_reg   <= '0;
            ctrl_reg      <= '0;
            stat_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            psc_limit_reg <= psc_limit_next;
            div_sel_reg   <= div_sel_next;
            psc_cnt_reg   <= psc_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            count_reg     <= count_next;
            reload_reg    <= reload_next;
            compare_reg   <= compare_next;
            ctrl_reg      <= ctrl_next;
            stat_reg      <= stat_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= {6'd0, core_expired, core_irq, core_rdata};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* src/pdct_core.sv */
// ----------------------------------------------------------------------------
// pdct_core
// Single-pass next-state and result logic for one timer request.
// ----------------------------------------------------------------------------
`default_nettype none

module pdct_core #(
    parameter int COUNT_WIDTH    = 32,
    parameter int PRESCALE_WIDTH = 8
) (
    input  var pdct_pkg::op_t               op,
    input  var pdct_pkg::reg_idx_t          reg_index,
    input  wire logic [31:0]                write_data,
    input  wire logic [PRESCALE_WIDTH-1:0]  psc_limit,
    input  wire logic [2:0]                 div_sel,
    input  wire logic [PRESCALE_WIDTH-1:0]  psc_cnt,
    input  wire logic [3:0]                 div_cnt,
    input  wire logic [COUNT_WIDTH-1:0]     count,
    input  wire logic [COUNT_WIDTH-1:0]     reload,
    input  wire logic [COUNT_WIDTH-1:0]     compare,
    input  var pdct_pkg::ctrl_t             ctrl,
    input  var pdct_pkg::stat_t             stat,
    output logic [PRESCALE_WIDTH-1:0]       psc_limit_next,
    output logic [2:0]                      div_sel_next,
    output logic [PRESCALE_WIDTH-1:0]       psc_cnt_next,
    output logic [3:0]                      div_cnt_next,
    output logic [COUNT_WIDTH-1:0]          count_next,
    output logic [COUNT_WIDTH-1:0]          reload_next,
    output logic [COUNT_WIDTH-1:0]          compare_next,
    output pdct_pkg::ctrl_t                 ctrl_next,
    output pdct_pkg::stat_t                 stat_next,
    output logic [31:0]                     read_data,
    output logic                            irq_line,
    output logic                            expired
);
    import pdct_pkg::*;

    logic [COUNT_WIDTH+31:0] wdata_wide;
    logic [COUNT_WIDTH-1:0]  wdata_cnt;
    logic [COUNT_WIDTH+31:0] count_wide;
    logic [COUNT_WIDTH+31:0] reload_wide;
    logic [COUNT_WIDTH+31:0] compare_wide;

    // resize between the 32-bit bus and the counter width
    assign wdata_wide   = {{COUNT_WIDTH{1'b0}}, write_data};
    assign wdata_cnt    = wdata_wide[COUNT_WIDTH-1:0];
    assign count_wide   = {32'd0, count};
    assign reload_wide  = {32'd0, reload};
    assign compare_wide = {32'd0, compare};

    always_comb
    begin
        psc_limit_next = psc_limit;
        div_sel_next   = div_sel;
        psc_cnt_next   = psc_cnt;
        div_cnt_next   = div_cnt;
        count_next     = count;
        reload_next    = reload;
        compare_next   = compare;
        ctrl_next      = ctrl;
        stat_next      = stat;
        read_data      = '0;
        expired        = 1'b0;

        case (op)
            OP_TICK:
            begin
                if (ctrl.run)
                begin
                    if (psc_cnt < psc_limit)
                    begin
                        psc_cnt_next = psc_cnt + 1'b1;
                    end
                    else
                    begin
                        psc_cnt_next = '0;
                        if (div_cnt < div_limit(div_sel))
                        begin
                            div_cnt_next = div_cnt + 4'd1;
                        end
                        else
                        begin
                            div_cnt_next = '0;
                            if (count != '0)
                            begin
                                count_next = count - 1'b1;
                            end
                            else
                            begin
                                expired        = 1'b1;
                                stat_next.flag = 1'b1;
                                if (ctrl.auto_reload)
                                    count_next = reload;
                                else
                                    ctrl_next.run = 1'b0;
                            end
                        end
                    end
                end
            end
            OP_READ:
            begin
                unique case (reg_index)
                    REG_CFG0:    read_data = {{(32-PRESCALE_WIDTH){1'b0}}, psc_limit};
                    REG_CFG1:    read_data = {29'd0, div_sel};
                    REG_CONTROL: read_data = {28'd0, ctrl};
                    REG_BUFFER:  read_data = reload_wide[31:0];
                    REG_COMPARE: read_data = compare_wide[31:0];
                    REG_COUNT:   read_data = count_wide[31:0];
                    REG_STATUS:  read_data = {26'd0, stat.flag, 4'd0, stat.enable};
                    default:     read_data = '0;
                endcase
            end
            OP_WRITE:
            begin
                unique case (reg_index)
                    REG_CFG0:    psc_limit_next = write_data[PRESCALE_WIDTH-1:0];
                    REG_CFG1:    div_sel_next   = write_data[2:0];
                    REG_CONTROL:
                    begin
                        ctrl_next = ctrl_t'(write_data[3:0]);
                        if (ctrl_next.update)
                        begin
                            count_next   = reload;
                            psc_cnt_next = '0;
                            div_cnt_next = '0;
                        end
                    end
                    REG_BUFFER:  reload_next  = wdata_cnt;
                    REG_COMPARE: compare_next = wdata_cnt;
                    REG_STATUS:
                    begin
                        stat_next.enable = write_data[STAT_EN_BIT];
                        if (write_data[STAT_FLAG_BIT])
                            stat_next.flag = 1'b0;
                    end
                    default: ;  // count is read-only, index 7 unused
                endcase
            end
            default: ;  // unused opcode
        endcase

        irq_line = stat_next.flag & stat_next.enable;
    end

endmodule

`default_nettype wire

/* src/pdct_checker.sv */
// ----------------------------------------------------------------------------
// pdct_checker
// Port-level assertions for the timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pdct_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // accepted request always yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request gave no result");

    // ready only when the result slot is free or drains
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not track result slot");

    // expiry comes from ticks only, which read nothing
    a_expired: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tdata[31:0] == 32'd0)
        else $error("expired result carries read data");

endmodule

bind prescaled_down_counting_timer pdct_checker u_pdct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the prescaled down-counting timer: a directed pass
// over one-shot, auto-reload and the timebase registers, then random
// countdown sequences under several prescale and divider settings, with
// random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------

module tb;

    import pdct_pkg::*;

    localparam logic [1:0] OP_NOP     = 2'd3;   // undefined request kind, does nothing
    localparam logic [2:0] REG_UNUSED = 3'd7;   // reads zero, writes dropped
    localparam int         IDLE_LIMIT = 2000;   // cycles with no transfer before giving up

    // one result word, field order as on m_tdata
    typedef struct packed {
        logic        expired;
        logic        irq_line;
        logic [31:0] read_data;
    } timer_reply_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [31:0] write_data
    logic [4:0]  s_tuser   = '0;   // [1:0] opcode, [4:2] reg_index
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // [31:0] read_data, [32] irq_line, [33] expired
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    prescaled_down_counting_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Timer mirror, all zero at reset
    // ------------------------------------------------------------------------
    logic [7:0]  tb_prescale = '0;
    logic [2:0]  tb_divsel   = '0;
    logic [7:0]  tb_psc_cnt  = '0;
    logic [3:0]  tb_div_cnt  = '0;
    logic [31:0] tb_count    = '0;
    logic [31:0] tb_reload   = '0;
    logic [31:0] tb_compare  = '0;
    ctrl_t       tb_ctrl     = '0;
    logic        tb_irq_en   = 1'b0;
    logic        tb_flag     = 1'b0;

    timer_reply_t replies_due[$];
    timer_reply_t got_reply;
    timer_reply_t want_reply;
    int           mismatches    = 0;
    int           requests_sent = 0;
    int           hold_off_left = 0;
    int           idle_cycles   = 0;
    bit           gaps_on       = 1'b1;

    // Applies one request to the mirror and returns the result it yields.
    function automatic timer_reply_t advance_timer(input logic [1:0] op,
                                                   input logic [2:0] idx,
                                                   input logic [31:0] data);
        timer_reply_t r;
        logic [3:0]   div_top;
        logic [31:0]  stat;
        r = '0;
        case (tb_divsel)
            3'd0:    div_top = 4'd0;
            3'd1:    div_top = 4'd1;
            3'd2:    div_top = 4'd3;
            3'd3:    div_top = 4'd7;
            default: div_top = 4'd15;   // 4 and above all divide by 16
        endcase
        if (op == OP_TICK)
        begin
            if (tb_ctrl.run)
            begin
                if (tb_psc_cnt < tb_prescale)
                    tb_psc_cnt = tb_psc_cnt + 8'd1;
                else
                begin
                    tb_psc_cnt = '0;
                    if (tb_div_cnt < div_top)
                        tb_div_cnt = tb_div_cnt + 4'd1;
                    else
                    begin
                        tb_div_cnt = '0;
                        if (tb_count != 32'd0)
                            tb_count = tb_count - 32'd1;
                        else
                        begin
                            r.expired = 1'b1;
                            tb_flag   = 1'b1;
                            if (tb_ctrl.auto_reload)
                                tb_count = tb_reload;
                            else
                                tb_ctrl.run = 1'b0;
                        end
                    end
                end
            end
        end
        else if (op == OP_READ)
        begin
            case (idx)
                REG_CFG0:    r.read_data = 32'(tb_prescale);
                REG_CFG1:    r.read_data = 32'(tb_divsel);
                REG_CONTROL: r.read_data = 32'(tb_ctrl);
                REG_BUFFER:  r.read_data = tb_reload;
                REG_COMPARE: r.read_data = tb_compare;
                REG_COUNT:   r.read_data = tb_count;
                REG_STATUS:
                begin
                    stat = '0;
                    stat[STAT_EN_BIT]   = tb_irq_en;
                    stat[STAT_FLAG_BIT] = tb_flag;
                    r.read_data = stat;
                end
                default:     r.read_data = '0;
            endcase
        end
        else if (op == OP_WRITE)
        begin
            case (idx)
                REG_CFG0:    tb_prescale = data[7:0];
                REG_CFG1:    tb_divsel   = data[2:0];
                REG_CONTROL:
                begin
                    tb_ctrl = ctrl_t'(data[3:0]);
                    // manual update: load now and restart the dividers
                    if (tb_ctrl.update)
                    begin
                        tb_count   = tb_reload;
                        tb_psc_cnt = '0;
                        tb_div_cnt = '0;
                    end
                end
                REG_BUFFER:  tb_reload  = data;
                REG_COMPARE: tb_compare = data;
                REG_STATUS:
                begin
                    tb_irq_en = data[STAT_EN_BIT];
                    if (data[STAT_FLAG_BIT])
                        tb_flag = 1'b0;
                end
                default: ;   // count register and index 7 drop writes
            endcase
        end
        r.irq_line = tb_flag & tb_irq_en;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic issue_request(input logic [1:0] op, input logic [2:0] idx,
                                 input logic [31:0] data);
        while (gaps_on && $urandom_range(0, 99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {idx, op};
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        replies_due.push_back(advance_timer(op, idx, data));
        requests_sent++;
    endtask

    // Settles the block, then sets the timebase through the config port.
    task automatic write_timebase(input logic [7:0] prescale, input logic [2:0] divsel);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRESCALE;
        cfg_data  <= prescale;
        @(posedge clk);
        cfg_index <= CFG_DIVIDER;
        cfg_data  <= {5'($urandom), divsel};   // upper bits must be dropped
        @(posedge clk);
        cfg_we <= 1'b0;
        tb_prescale = prescale;
        tb_divsel   = divsel;
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each result, then pick next m_tready
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            got_reply = timer_reply_t'(m_tdata[33:0]);
            if (replies_due.size() == 0)
            begin
                $display("%0t: result with none due, actual %h", $time, got_reply);
                mismatches++;
            end
            else
            begin
                want_reply = replies_due.pop_front();
                if (got_reply.read_data !== want_reply.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             want_reply.read_data, got_reply.read_data);
                    mismatches++;
                end
                if (got_reply.irq_line !== want_reply.irq_line)
                begin
                    $display("%0t: irq_line expected %b actual %b", $time,
                             want_reply.irq_line, got_reply.irq_line);
                    mismatches++;
                end
                if (got_reply.expired !== want_reply.expired)
                begin
                    $display("%0t: expired expected %b actual %b", $time,
                             want_reply.expired, got_reply.expired);
                    mismatches++;
                end
            end
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_left > 0)
        begin
            hold_off_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(gaps_on && $urandom_range(0, 99) < 11);
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Load 2, run without auto-reload: 2, 1, 0, then expiry stops the timer.
    task automatic test_single_shot();
        issue_request(OP_WRITE, REG_BUFFER, 32'd2);
        issue_request(OP_WRITE, REG_COUNT, 32'hFFFF_FFFF);   // read-only
        issue_request(OP_READ, REG_COUNT, 32'hFFFF_FFFF);
        issue_request(OP_WRITE, REG_COMPARE, 32'hFFFF_FFFF);
        issue_request(OP_WRITE, REG_UNUSED, 32'hFFFF_FFFF);
        issue_request(OP_READ, REG_UNUSED, '0);
        issue_request(OP_WRITE, REG_STATUS, 32'h21);          // enable, clear flag
        issue_request(OP_WRITE, REG_CONTROL, 32'h3);          // update + run
        repeat (4) issue_request(OP_TICK, '0, '0);
        issue_request(OP_TICK, '0, '0);                       // stopped now
        issue_request(OP_READ, REG_STATUS, '0);
        issue_request(OP_NOP, REG_STATUS, 32'hFFFF_FFFF);
    endtask

    // All control bits set: expiry reloads and keeps running.
    task automatic test_auto_reload();
        issue_request(OP_WRITE, REG_STATUS, 32'h20);
        issue_request(OP_WRITE, REG_CONTROL, 32'hF);
        repeat (4) issue_request(OP_TICK, '0, '0);
        issue_request(OP_READ, REG_CONTROL, '0);
    endtask

    // Timebase through the bus, including a divider select above 4.
    task automatic test_timebase_registers();
        issue_request(OP_WRITE, REG_CFG0, 32'hFFFF_FFFF);
        issue_request(OP_WRITE, REG_CFG1, 32'hFFFF_FFFF);
        issue_request(OP_READ, REG_CFG0, '0);
        issue_request(OP_READ, REG_CFG1, '0);
        issue_request(OP_READ, REG_COMPARE, '0);
    endtask

    // Buffer, control and a run of ticks with reads and stray requests mixed in.
    task automatic run_countdown_sequence();
        logic [31:0] data;
        logic [2:0]  idx;
        ctrl_t       ctl;
        int          n_ticks;
        int          pick;
        data = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
        issue_request(OP_WRITE, REG_BUFFER, data);
        if ($urandom_range(0, 1) == 1)
            issue_request(OP_WRITE, REG_STATUS, $urandom);
        ctl        = ctrl_t'(4'($urandom));
        ctl.update = ($urandom_range(0, 9) != 0);
        ctl.run    = ($urandom_range(0, 9) != 0);
        data       = $urandom;
        data[3:0]  = ctl;
        issue_request(OP_WRITE, REG_CONTROL, data);
        n_ticks = $urandom_range(4, 40);
        for (int k = 0; k < n_ticks; k++)
        begin
            pick = $urandom_range(0, 99);
            idx  = 3'($urandom);
            data = $urandom;
            // keep bus timebase writes fast so counts still reach zero
            if (idx == REG_CFG0)
                data[7:0] = 8'($urandom_range(0, 3));
            if (idx == REG_CFG1)
                data[2:0] = 3'($urandom_range(0, 2));
            if (pick < 75)
                issue_request(OP_TICK, idx, data);
            else if (pick < 85)
                issue_request(OP_READ, idx, data);
            else if (pick < 90)
                issue_request(OP_WRITE, REG_STATUS, data);
            else if (pick < 95)
                issue_request(OP_WRITE, idx, data);
            else
                issue_request(2'($urandom), idx, data);
        end
    endtask

    task automatic run_phase(input logic [7:0] prescale, input logic [2:0] divsel,
                             input int budget, input bit with_gaps);
        int start;
        write_timebase(prescale, divsel);
        gaps_on = with_gaps;
        start   = requests_sent;
        while (requests_sent - start < budget)
            run_countdown_sequence();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_countdowns();
        run_phase(8'd0, 3'd0, 300, 1'b0);      // no idling on either side
        run_phase(8'd0, 3'd0, 300, 1'b1);
        run_phase(8'd1, 3'd1, 300, 1'b1);
        run_phase(8'd255, 3'd4, 150, 1'b1);
        run_phase(8'd0, 3'd4, 200, 1'b1);
        run_phase(8'd255, 3'd0, 200, 1'b1);
        run_phase(8'($urandom_range(0, 3)), 3'($urandom_range(0, 2)), 250, 1'b1);
    endtask

    // Receiver stalls for a long stretch; requests keep coming until the
    // block fills and drops s_tready.
    task automatic test_output_backpressure();
        hold_off_left = 300;
        for (int k = 0; k < 40; k++)
            issue_request(($urandom_range(0, 3) == 0) ? OP_READ : OP_TICK,
                          REG_COUNT, $urandom);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_shot();
        test_auto_reload();
        test_timebase_registers();
        test_random_countdowns();
        test_output_backpressure();

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
src/pdct_pkg.sv
src/pdct_core.sv
src/prescaled_down_counting_timer.sv
src/pdct_checker.sv
tb/sv/tb.sv
